// ===== rtl/softmax_top_k_expert_router_assert.svh =====
// Assertion macros shared by the router RTL.
`ifndef SOFTMAX_TOP_K_EXPERT_ROUTER_ASSERT_SVH
`define SOFTMAX_TOP_K_EXPERT_ROUTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMTK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SMTK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/smtk_pkg.sv =====
// ----------------------------------------------------------------------------
// smtk_pkg
// Shared types, widths and the exponential factor table of the expert router.
// ----------------------------------------------------------------------------
package smtk_pkg;

  localparam int LOGIT_W = 16;
  localparam int PROB_W  = 16;
  localparam int EXP_W   = 17;
  localparam int NUM_W   = 34;
  localparam int INDEX_W = 6;

  // Configuration register indexes.
  localparam logic CFG_EXPERT_COUNT = 1'b0;
  localparam logic CFG_PICKS_WANTED = 1'b1;

  // Response of the exponential unit.
  typedef struct packed {
    logic             done;
    logic [EXP_W-1:0] value;
  } exp_rsp_t;

  // Response of the divider.
  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] quotient;
  } div_rsp_t;

  // exp(-2^b / 256) in Q0.32 for b = 0..11.
  function automatic logic [31:0] exp_factor(input logic [3:0] b);
    logic [31:0] f;
    case (b)
      4'd0:    f = 32'd4278222805;
      4'd1:    f = 32'd4261543595;
      4'd2:    f = 32'd4228380000;
      4'd3:    f = 32'd4162825044;
      4'd4:    f = 32'd4034748382;
      4'd5:    f = 32'd3790295335;
      4'd6:    f = 32'd3344923893;
      4'd7:    f = 32'd2605029347;
      4'd8:    f = 32'd1580030169;
      4'd9:    f = 32'd581260616;
      4'd10:   f = 32'd78665070;
      4'd11:   f = 32'd1440801;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/smtk_ram.sv =====
// ----------------------------------------------------------------------------
// smtk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smtk_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smtk_exp.sv =====
// ----------------------------------------------------------------------------
// smtk_exp
// Iterative exponential: 65536 * exp(-d/256), one bit of d per cycle.
// ----------------------------------------------------------------------------
module smtk_exp
  import smtk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LOGIT_W-1:0]   d,
  output exp_rsp_t             rsp
);

  logic        busy;
  logic        done;
  logic        zero;
  logic        one;
  logic [3:0]  cnt;
  logic [11:0] dbits;
  logic [31:0] acc;
  logic [31:0] factor;
  logic [63:0] prod;
  logic [32:0] rnd;

  // Rounded Q0.32 product for the current bit.
  assign factor = exp_factor(cnt);
  assign prod   = 64'(acc) * 64'(factor) + 64'h0000_0000_8000_0000;
  assign rnd    = {1'b0, acc} + 33'h0_0000_8000;

  // Walk the twelve bits of d; a distance of 16.0 or more gives zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (d[15:12] != 4'd0) begin
          zero <= 1'b1;
          done <= 1'b1;
        end else begin
          zero  <= 1'b0;
          one   <= 1'b1;
          busy  <= 1'b1;
          cnt   <= 4'd0;
          dbits <= d[11:0];
        end
      end else if (busy) begin
        if (dbits[cnt]) begin
          if (one) begin
            acc <= factor;
            one <= 1'b0;
          end else begin
            acc <= prod[63:32];
          end
        end
        if (cnt == 4'd11) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
    end
  end

  // Final rounding to Q0.16.
  always_comb begin
    rsp.done = done;
    if (zero) begin
      rsp.value = '0;
    end else if (one) begin
      rsp.value = 17'h1_0000;
    end else begin
      rsp.value = rnd[32:16];
    end
  end

endmodule

// ===== rtl/smtk_div.sv =====
// ----------------------------------------------------------------------------
// smtk_div
// Restoring divider, one quotient bit per cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module smtk_div
  import smtk_pkg::*;
#(
  parameter int SW = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SW-1:0]    den,
  output div_rsp_t         rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] numr;
  logic [NUM_W-1:0] quo;
  logic [SW:0]      rem;
  logic [SW-1:0]    den_r;
  logic [SW:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem[SW-1:0], numr[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  // Shift in one numerator bit and try a subtract each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        numr  <= num;
        den_r <= den;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        numr <= numr << 1;
        if (fits) begin
          rem <= rem_sh - {1'b0, den_r};
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = (|quo[NUM_W-1:PROB_W]) ? {PROB_W{1'b1}} : quo[PROB_W-1:0];

endmodule

// ===== rtl/softmax_top_k_expert_router.sv =====
// ----------------------------------------------------------------------------
// softmax_top_k_expert_router
// Softmax top-k gating: stores one logit per transaction and, when a token is
// complete, emits the top experts with their softmax probabilities.
// ----------------------------------------------------------------------------
// Each input transaction that does not complete a token is taken without a
// stall. When any picks are wanted, the transaction that completes a token of
// n logits holds the input off while the token is worked through the logit
// RAM: for each expert one RAM read and the 12-step exponential unit for the
// exponential sum, then for each pick a scan over the RAM and, if an expert is
// found, the exponential and the bit-serial divider, then the result at the
// output register.
module softmax_top_k_expert_router
  import smtk_pkg::*;
#(
  parameter int MAX_EXPERTS = 64,
  parameter int MAX_PICKS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  gate_logit,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  expert_index,
  output logic                expert_found,
  output logic [PROB_W-1:0]   probability,
  output logic                last_pick
);

  `include "softmax_top_k_expert_router_assert.svh"

  localparam int EW = $clog2(MAX_EXPERTS);
  localparam int CW = $clog2(MAX_EXPERTS + 1);
  localparam int PW = $clog2(MAX_PICKS + 1);
  localparam int SW = EXP_W + EW;
  localparam int MW = LOGIT_W + 1;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SUM_RD    = 4'd1;
  localparam logic [3:0] ST_SUM_EXP   = 4'd2;
  localparam logic [3:0] ST_SUM_WAIT  = 4'd3;
  localparam logic [3:0] ST_SEL       = 4'd4;
  localparam logic [3:0] ST_SEL_END   = 4'd5;
  localparam logic [3:0] ST_PICK_CHK  = 4'd6;
  localparam logic [3:0] ST_PICK_WAIT = 4'd7;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd8;
  localparam logic [3:0] ST_OUT       = 4'd9;

  logic [3:0]          state;
  logic [6:0]          expert_count;
  logic [3:0]          picks_wanted;
  logic [CW-1:0]       arrival_count;
  logic signed [15:0]  running_maximum;

  logic [CW-1:0]       need;
  logic [PW-1:0]       picks_sat;
  logic                in_accept;
  logic [CW-1:0]       count_next;
  logic signed [15:0]  max_next;
  logic                complete;

  logic [CW-1:0]       n_lat;
  logic [PW-1:0]       picks_lat;
  logic signed [15:0]  max_lat;
  logic [SW-1:0]       sum;
  logic [EW-1:0]       idx;
  logic                cmp_valid;
  logic [EW-1:0]       cmp_idx;
  logic                found;
  logic [EW-1:0]       best;
  logic signed [15:0]  best_logit;
  logic [PW-1:0]       pick_cnt;
  logic [PROB_W-1:0]   prob;

  logic                ram_we;
  logic [EW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [MW-1:0]       ram_rdata;
  logic signed [15:0]  rd_logit;

  logic                exp_start;
  logic [LOGIT_W-1:0]  exp_d;
  exp_rsp_t            exp_rsp;
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  div_rsp_t            div_rsp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expert_count <= 7'd64;
      picks_wanted <= 4'd6;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EXPERT_COUNT: expert_count <= cfg_data;
        CFG_PICKS_WANTED: picks_wanted <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the configured counts to the supported range.
  always_comb begin
    if (expert_count == 7'd0) begin
      need = CW'(1);
    end else if (32'(expert_count) > MAX_EXPERTS) begin
      need = CW'(MAX_EXPERTS);
    end else begin
      need = CW'(expert_count);
    end
    if (32'(picks_wanted) > MAX_PICKS) begin
      picks_sat = PW'(MAX_PICKS);
    end else begin
      picks_sat = PW'(picks_wanted);
    end
  end

  // Arrival bookkeeping for the incoming transaction.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign count_next = (32'(arrival_count) < MAX_EXPERTS) ?
                      arrival_count + CW'(1) : arrival_count;
  assign max_next  = (gate_logit > running_maximum) ? gate_logit : running_maximum;
  assign complete  = count_next >= need;

  // Logit RAM: each entry holds a picked mark above the logit.
  assign rd_logit = ram_rdata[LOGIT_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = arrival_count[EW-1:0];
    ram_wdata = {1'b0, gate_logit};
    if (in_accept && (32'(arrival_count) < MAX_EXPERTS)) begin
      ram_we = 1'b1;
    end else if ((state == ST_PICK_CHK) && found) begin
      ram_we    = 1'b1;
      ram_waddr = best;
      ram_wdata = {1'b1, best_logit};
    end
  end

  smtk_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_EXPERTS)
  ) u_logit_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Exponential of the distance to the maximum, for the sum or for a pick.
  assign exp_start = (state == ST_SUM_EXP) || ((state == ST_PICK_CHK) && found);
  assign exp_d     = (state == ST_SUM_EXP) ? LOGIT_W'(max_lat - rd_logit)
                                           : LOGIT_W'(max_lat - best_logit);

  smtk_exp u_exp (
    .clk  (clk),
    .rst  (rst),
    .start(exp_start),
    .d    (exp_d),
    .rsp  (exp_rsp)
  );

  // Rounded probability numerator: e * 65536 + sum / 2.
  assign div_start = (state == ST_PICK_WAIT) && exp_rsp.done;
  assign div_num   = NUM_W'({exp_rsp.value, 16'h0000}) + NUM_W'(sum >> 1);

  smtk_div #(
    .SW(SW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (sum),
    .rsp  (div_rsp)
  );

  // Token sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      arrival_count   <= '0;
      running_maximum <= 16'sh8000;
      cmp_valid       <= 1'b0;
    end else begin
      cmp_valid <= (state == ST_SEL);
      cmp_idx   <= idx;
      // Scan compare on the entry read in the previous cycle.
      if (cmp_valid && !ram_rdata[LOGIT_W] && (!found || (rd_logit > best_logit))) begin
        found      <= 1'b1;
        best       <= cmp_idx;
        best_logit <= rd_logit;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (complete) begin
              arrival_count   <= '0;
              running_maximum <= 16'sh8000;
              n_lat           <= count_next;
              max_lat         <= max_next;
              picks_lat       <= picks_sat;
              sum             <= '0;
              idx             <= '0;
              pick_cnt        <= '0;
              if (picks_sat != '0) begin
                state <= ST_SUM_RD;
              end
            end else begin
              arrival_count   <= count_next;
              running_maximum <= max_next;
            end
          end
        end
        ST_SUM_RD: begin
          state <= ST_SUM_EXP;
        end
        ST_SUM_EXP: begin
          state <= ST_SUM_WAIT;
        end
        ST_SUM_WAIT: begin
          if (exp_rsp.done) begin
            sum <= sum + SW'(exp_rsp.value);
            if (CW'(idx) == n_lat - CW'(1)) begin
              idx   <= '0;
              found <= 1'b0;
              state <= ST_SEL;
            end else begin
              idx   <= idx + EW'(1);
              state <= ST_SUM_RD;
            end
          end
        end
        ST_SEL: begin
          if (CW'(idx) == n_lat - CW'(1)) begin
            state <= ST_SEL_END;
          end else begin
            idx <= idx + EW'(1);
          end
        end
        ST_SEL_END: begin
          state <= ST_PICK_CHK;
        end
        ST_PICK_CHK: begin
          if (found) begin
            state <= ST_PICK_WAIT;
          end else begin
            prob  <= '0;
            state <= ST_OUT;
          end
        end
        ST_PICK_WAIT: begin
          if (exp_rsp.done) begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            prob  <= div_rsp.quotient;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (last_pick) begin
              state <= ST_IDLE;
            end else begin
              pick_cnt <= pick_cnt + PW'(1);
              idx      <= '0;
              found    <= 1'b0;
              state    <= ST_SEL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register outputs.
  assign out_valid    = (state == ST_OUT);
  assign expert_found = found;
  assign expert_index = found ? INDEX_W'(best) : '0;
  assign probability  = prob;
  assign last_pick    = (pick_cnt + PW'(1)) == picks_lat;

  // No input transaction is taken while a result is offered.
  `SMTK_ASSERT_NOW(a_stall_on_result, clk, rst, out_valid, in_stall,
                   "input accepted while a result is pending")
  // A pick beyond the expert count carries a zero probability.
  `SMTK_ASSERT_NOW(a_empty_pick_zero, clk, rst, out_valid && !expert_found,
                   (probability == '0) && (expert_index == '0),
                   "empty pick with nonzero payload")
  // The arrival count is cleared while a token is being reported.
  `SMTK_ASSERT_NOW(a_count_cleared, clk, rst, out_valid, arrival_count == '0,
                   "arrival count not cleared during token results")
  // After the final result the block returns to taking logits.
  `SMTK_ASSERT_NEXT(a_back_to_idle, clk, rst, out_valid && !out_stall && last_pick,
                    !out_valid && !in_stall, "block did not return to idle")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the softmax top-k expert router: a table of
// directed tokens, then random tokens over many settings, all checked
// transaction by transaction against an in-bench model of the gating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import smtk_pkg::*;
();

  localparam int N_EXPERTS   = 64;
  localparam int N_PICKS     = 8;
  localparam int CFG_HOLDOFF = 3000;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_GOAL = 420;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic               found;
    logic [PROB_W-1:0]  prob;
    logic               last;
  } pick_t;

  typedef struct {
    int                 count;
    int                 picks;
    logic signed [15:0] logit;
    bit                 lone;   // single-expert token, results typed in
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [0:0]          cfg_index = CFG_EXPERT_COUNT;
  logic [6:0]          cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [15:0]  gate_logit = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [INDEX_W-1:0]  expert_index;
  logic                expert_found;
  logic [PROB_W-1:0]   probability;
  logic                last_pick;

  // Model state and configuration.
  logic signed [15:0] logit_mem [N_EXPERTS];
  bit                 taken [N_EXPERTS];
  int                 arrived = 0;
  int                 peak = -32768;
  logic [6:0]         count_reg = 7'd64;
  logic [3:0]         picks_reg = 4'd6;

  pick_t pending_picks [$];
  int    errors = 0;
  int    items_sent = 0;
  int    picks_checked = 0;
  int    tokens_done = 0;
  int    cycles = 0;
  int    idle_mode = 0;
  bit    held = 1'b0;
  int    hold_left = 0;

  logic [31:0] exp_step [12] = '{
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260616,  32'd78665070,   32'd1440801
  };

  row_t directed [] = '{
    '{1, 2, 16'sh7FFF, 1}, '{1, 2, -16'sh8000, 1}, '{1, 1, 16'sh0000, 1},
    // Ties between the two maxima, an exponent underflow, picks past experts.
    '{4, 8, -16'sh8000, 0}, '{4, 8, 16'sh7FFF, 0}, '{4, 8, 16'sh7FFF, 0},
    '{4, 8, 16'sh0000, 0},
    // Zero expert count acts as one.
    '{0, 3, 16'sh0064, 1},
    // Zero picks: tokens complete silently.
    '{3, 0, 16'sh0005, 0}, '{3, 0, 16'sh0006, 0}, '{3, 0, 16'sh0007, 0},
    // Picks above the maximum saturate.
    '{2, 15, 16'sh0100, 0}, '{2, 15, -16'sh0100, 0},
    // Count lowered in the middle of a token.
    '{64, 5, 16'sh0010, 0}, '{64, 5, -16'sh0200, 0}, '{64, 5, 16'sh0300, 0},
    '{64, 5, 16'sh0010, 0}, '{64, 5, 16'sh7FFF, 0}, '{64, 5, -16'sh8000, 0},
    '{64, 5, 16'sh0001, 0}, '{64, 5, 16'sh0002, 0}, '{64, 5, 16'sh0fff, 0},
    '{64, 5, 16'sh1000, 0}, '{2, 5, 16'sh0011, 0}
  };

  softmax_top_k_expert_router DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .gate_logit,
    .out_valid, .out_stall, .expert_index, .expert_found, .probability, .last_pick
  );

  // Clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // 65536 * exp(-d/256) in Q0.16, built from the per-bit factors.
  function automatic logic [16:0] exp_weight(input int unsigned d);
    logic [63:0] acc;
    acc = 64'd1 << 32;
    if (d >= 4096) return '0;
    for (int b = 0; b < 12; b++)
      if (d[b]) acc = (acc * exp_step[b] + (64'd1 << 31)) >> 32;
    return 17'((acc + 64'h8000) >> 16);
  endfunction

  // Take one logit into the model and queue the picks of a finished token.
  task automatic absorb_logit(input logic signed [15:0] v, input bit lone);
    int          need;
    int          picks;
    int          best;
    int          best_score;
    bit          found;
    logic [63:0] total;
    logic [63:0] e;
    logic [63:0] q;
    pick_t       r;
    need  = (count_reg == 0) ? 1 : (count_reg > N_EXPERTS ? N_EXPERTS : count_reg);
    picks = (picks_reg > N_PICKS) ? N_PICKS : picks_reg;
    if (arrived < N_EXPERTS) begin
      logit_mem[arrived] = v;
      arrived++;
    end
    if (int'(v) > peak) peak = int'(v);
    if (arrived < need) return;
    total = 0;
    for (int i = 0; i < arrived; i++) begin
      taken[i] = 1'b0;
      total += exp_weight(peak - int'(logit_mem[i]));
    end
    for (int p = 0; p < picks; p++) begin
      found = 1'b0;
      best = 0;
      best_score = 0;
      for (int i = 0; i < arrived; i++)
        if (!taken[i] && (!found || int'(logit_mem[i]) > best_score)) begin
          found = 1'b1;
          best = i;
          best_score = int'(logit_mem[i]);
        end
      q = 0;
      if (found) begin
        taken[best] = 1'b1;
        e = exp_weight(peak - best_score);
        q = ((e << 16) + total / 2) / total;
        if (q > 65535) q = 65535;
      end
      r.index = found ? INDEX_W'(best) : '0;
      r.found = found;
      r.prob  = PROB_W'(q);
      r.last  = (p + 1 == picks);
      // A lone expert takes all the probability and nothing else is found.
      if (lone) r = '{'0, p == 0, (p == 0) ? 16'hFFFF : 16'h0000, p + 1 == picks};
      pending_picks.push_back(r);
    end
    arrived = 0;
    peak = -32768;
    tokens_done++;
  endtask

  // Write both registers once the block has drained; called at a posedge.
  task automatic set_config(input int count, input int picks);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (CFG_HOLDOFF) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_EXPERT_COUNT;
    cfg_data  <= 7'(count);
    @(posedge clk);
    cfg_index <= CFG_PICKS_WANTED;
    cfg_data  <= 7'(picks);
    @(posedge clk);
    cfg_write <= 1'b0;
    count_reg = 7'(count);
    picks_reg = 4'(picks);
  endtask

  // Offer one logit until the block takes it; entered and left at a posedge.
  task automatic send_logit(input logic signed [15:0] v, input bit lone);
    bit ok;
    while ((idle_mode == 0 && $urandom_range(99) < 14) ||
           (idle_mode == 1 && $urandom_range(99) < 71)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    gate_logit <= v;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    absorb_logit(v, lone);
  endtask

  // Random logit: full range, a narrow band full of ties, or a mid band.
  function automatic logic signed [15:0] rand_logit(input int style);
    case (style)
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // Result receiver with random stalls and one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (!held && items_sent >= 200) begin
        held = 1'b1;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_mode == 0) begin
        out_stall <= ($urandom_range(99) < 71);
      end else if (idle_mode == 1) begin
        out_stall <= ($urandom_range(99) < 14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest expected pick.
  always @(negedge clk) begin
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected result: index %0d prob %0d", expert_index, probability);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        picks_checked++;
        if (expert_index !== want.index) begin
          $error("expert_index: expected %0d, got %0d", want.index, expert_index);
          errors++;
        end
        if (expert_found !== want.found) begin
          $error("expert_found: expected %0d, got %0d", want.found, expert_found);
          errors++;
        end
        if (probability !== want.prob) begin
          $error("probability: expected %0d, got %0d", want.prob, probability);
          errors++;
        end
        if (last_pick !== want.last) begin
          $error("last_pick: expected %0d, got %0d", want.last, last_pick);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int count;
    int picks;
    int tokens;
    int style;
    int need;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; registers change only where the row asks.
    count = -1;
    picks = -1;
    foreach (directed[i]) begin
      if (directed[i].count != count || directed[i].picks != picks) begin
        in_valid <= 1'b0;
        count = directed[i].count;
        picks = directed[i].picks;
        set_config(count, picks);
      end
      send_logit(directed[i].logit, directed[i].lone);
    end

    // Random tokens: the largest settings every other round until 40 tokens are done, then mostly small tokens.
    items_sent = 0;
    while (items_sent < RANDOM_GOAL) begin
      idle_mode = (items_sent < RANDOM_GOAL / 3) ? 0 :
                  (items_sent < 2 * RANDOM_GOAL / 3) ? 1 : 2;
      if (tokens_done < 40 && count != 127) begin
        count = 127;
        picks = 15;
      end else if ($urandom_range(9) == 0) begin
        count = 64;
        picks = 8;
      end else begin
        count = $urandom_range(12);
        picks = $urandom_range(15);
      end
      in_valid <= 1'b0;
      set_config(count, picks);
      need = (count == 0) ? 1 : (count > N_EXPERTS ? N_EXPERTS : count);
      tokens = (need > 16) ? 1 : $urandom_range(3, 6);
      style = $urandom_range(2);
      repeat (tokens * need) send_logit(rand_logit(style), 1'b0);
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle.
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (CFG_HOLDOFF) @(posedge clk);
    $display("tb: %0d tokens over many settings, %0d picks checked",
             tokens_done, picks_checked);
    if (errors == 0 && pending_picks.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
